// File: sv/co2_sensor_frame_parser_defines.svh
// Assertion helpers for the sensor frame parser.
`ifndef CO2_SENSOR_FRAME_PARSER_DEFINES_SVH
`define CO2_SENSOR_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/csfp_pkg.sv
package csfp_pkg;

    localparam logic [7:0]  START_BYTE = 8'hBB;
    localparam logic [7:0]  HDR_BYTE1  = 8'h66;
    localparam logic [7:0]  HDR_BYTE2  = 8'h15;
    localparam logic [7:0]  HDR_BYTE3  = 8'h02;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  MAX_ERRORS_RESET = 8'd10;

    typedef enum logic [1:0] {
        KIND_GOOD    = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_CRC     = 2'd2,
        KIND_TIMEOUT = 2'd3
    } t_err_kind;

    typedef enum logic [2:0] {
        POS_HUNT  = 3'd0,
        POS_HDR1  = 3'd1,
        POS_HDR2  = 3'd2,
        POS_HDR3  = 3'd3,
        POS_VALLO = 3'd4,
        POS_VALHI = 3'd5,
        POS_CRCLO = 3'd6,
        POS_CRCHI = 3'd7
    } t_frame_pos;

    // One byte of CRC-16/MODBUS, reflected, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/co2_sensor_frame_parser.sv
// Channel   | Dir | Payload
// ----------+-----+-------------------------------------------------------
// s_axis    | in  | tdata[7:0] data_byte, tuser[0] func (1 = timeout)
// m_axis    | out | tdata[15:0] co2_value, tuser[0] valid_res,
//           |     | tuser[2:1] error_kind
// cfg       | in  | i_cfg_we, i_cfg_wdata[7:0] max_errors
//
// One request per cycle is accepted while the output is not stalled; it is registered,
// decoded, and its result (if any) lands in the output register when that register advances.
// The byte-wide CRC step between the input and result registers sets the cycle time.
// Reset is synchronous, active low; it clears the frame state and sets max_errors to 10.
// A stalled output holds the input stage; the input accepts again as soon as the output
// register drains.
`include "co2_sensor_frame_parser_defines.svh"

module co2_sensor_frame_parser
    import csfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] co2_value
    output logic [2:0]  o_m_axis_tuser,   // [0] valid_res, [2:1] error_kind
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    logic        r_in_valid;
    logic        r_func;
    logic [7:0]  r_byte;

    t_frame_pos  r_pos,       n_pos;
    logic [15:0] r_crc,       n_crc;
    logic [15:0] r_value,     n_value;
    logic [7:0]  r_crc_lo,    n_crc_lo;
    logic [15:0] r_last,      n_last;
    logic [7:0]  r_err_cnt,   n_err_cnt;
    logic [7:0]  r_max_errors;

    logic        r_out_valid;
    logic [15:0] r_out_value;
    logic        r_out_ok;
    t_err_kind   r_out_kind;

    logic        n_has_res;
    logic [15:0] n_res_value;
    logic        n_res_ok;
    t_err_kind   n_res_kind;

    logic        adv;
    logic        err;
    t_err_kind   err_kind;
    logic [15:0] crc_next;
    logic [7:0]  hdr_expect;

    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || adv;

    assign crc_next = crc_feed(r_crc, r_byte);

    always_comb begin
        unique case (r_pos)
            POS_HDR1: hdr_expect = HDR_BYTE1;
            POS_HDR2: hdr_expect = HDR_BYTE2;
            default:  hdr_expect = HDR_BYTE3;
        endcase
    end

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_value   = r_value;
        n_crc_lo  = r_crc_lo;
        n_last    = r_last;
        n_err_cnt = r_err_cnt;
        n_has_res = 1'b0;
        n_res_value = r_value;
        n_res_ok    = 1'b1;
        n_res_kind  = KIND_GOOD;
        err      = 1'b0;
        err_kind = KIND_TIMEOUT;

        if (r_func) begin
            err = 1'b1;
        end else begin
            unique case (r_pos)
                POS_HUNT: begin
                    if (r_byte == START_BYTE) begin
                        n_crc = crc_feed(CRC_INIT, r_byte);
                        n_pos = POS_HDR1;
                    end
                end
                POS_HDR1, POS_HDR2, POS_HDR3: begin
                    if (r_byte != hdr_expect) begin
                        err      = 1'b1;
                        err_kind = KIND_HEADER;
                    end else begin
                        n_crc = crc_next;
                        n_pos = t_frame_pos'(r_pos + 3'd1);
                    end
                end
                POS_VALLO: begin
                    n_value = {8'h00, r_byte};
                    n_crc   = crc_next;
                    n_pos   = POS_VALHI;
                end
                POS_VALHI: begin
                    n_value = {r_byte, r_value[7:0]};
                    n_crc   = crc_next;
                    n_pos   = POS_CRCLO;
                end
                POS_CRCLO: begin
                    n_crc_lo = r_byte;
                    n_pos    = POS_CRCHI;
                end
                POS_CRCHI: begin
                    if ({r_byte, r_crc_lo} != r_crc) begin
                        err      = 1'b1;
                        err_kind = KIND_CRC;
                    end else begin
                        n_last      = r_value;
                        n_err_cnt   = 8'd0;
                        n_has_res   = 1'b1;
                        n_res_value = r_value;
                        n_res_ok    = 1'b1;
                        n_res_kind  = KIND_GOOD;
                        n_pos       = POS_HUNT;
                        n_crc       = CRC_INIT;
                    end
                end
                default: begin
                    n_pos = POS_HUNT;
                end
            endcase
        end

        // Every error reports the held value until the limit is reached, then zero.
        if (err) begin
            n_has_res  = 1'b1;
            n_res_kind = err_kind;
            n_pos      = POS_HUNT;
            n_crc      = CRC_INIT;
            if (r_err_cnt < r_max_errors) begin
                n_err_cnt   = r_err_cnt + 8'd1;
                n_res_value = r_last;
                n_res_ok    = 1'b1;
            end else begin
                n_res_value = 16'd0;
                n_res_ok    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pos        <= POS_HUNT;
            r_crc        <= CRC_INIT;
            r_value      <= 16'd0;
            r_crc_lo     <= 8'd0;
            r_last       <= 16'd0;
            r_err_cnt    <= 8'd0;
            r_max_errors <= MAX_ERRORS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_errors <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
                r_func     <= i_s_axis_tuser;
                r_byte     <= i_s_axis_tdata;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && n_has_res;
                r_out_value <= n_res_value;
                r_out_ok    <= n_res_ok;
                r_out_kind  <= n_res_kind;
                if (r_in_valid) begin
                    r_pos     <= n_pos;
                    r_crc     <= n_crc;
                    r_value   <= n_value;
                    r_crc_lo  <= n_crc_lo;
                    r_last    <= n_last;
                    r_err_cnt <= n_err_cnt;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = {r_out_kind, r_out_ok};

    `CSFP_ASSERT_IMP(a_invalid_is_zero, i_clk, i_rst_n, r_out_valid && !r_out_ok,
        r_out_value == 16'd0, "invalid result carries a nonzero value")
    `CSFP_ASSERT_IMP(a_good_is_valid, i_clk, i_rst_n, r_out_valid && r_out_kind == KIND_GOOD,
        r_out_ok, "good frame reported without valid")
    `CSFP_ASSERT_NEXT(a_timeout_hunts, i_clk, i_rst_n, adv && r_in_valid && r_func,
        r_pos == POS_HUNT && r_crc == CRC_INIT && r_out_valid,
        "timeout did not restart the hunt")

endmodule

// File: tb/tb_co2_sensor_frame_parser.sv
module tb_co2_sensor_frame_parser import csfp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [15:0] value;
        logic        valid;
        t_err_kind   kind;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        i_s_axis_tuser = 1'b0;    // [0] func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;           // [15:0] co2_value
    logic [2:0]  o_m_axis_tuser;           // [0] valid_res, [2:1] error_kind
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'h00;

    co2_sensor_frame_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Parser state as the testbench tracks it.
    t_frame_pos  trk_pos = POS_HUNT;
    logic [15:0] trk_crc = CRC_INIT;
    logic [15:0] trk_value = 16'h0000;
    logic [7:0]  trk_crc_lo = 8'h00;
    logic [15:0] trk_last = 16'h0000;
    logic [7:0]  trk_err_count = 8'h00;
    logic [7:0]  trk_err_limit = MAX_ERRORS_RESET;

    t_reading pending_readings[$];
    int       fail_count = 0;
    int       stuck_cycles = 0;
    logic     sender_quiet = 1'b0;
    logic     reader_quiet = 1'b0;

    // Bitwise form of the reflected MODBUS CRC update.
    function automatic logic [15:0] crc_modbus_byte(input logic [15:0] acc,
                                                    input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void record_error(input t_err_kind kind);
        t_reading r;
        if (trk_err_count < trk_err_limit) begin
            trk_err_count = trk_err_count + 8'd1;
            r.value = trk_last;
            r.valid = 1'b1;
        end else begin
            r.value = 16'h0000;
            r.valid = 1'b0;
        end
        r.kind = kind;
        pending_readings.push_back(r);
        trk_pos = POS_HUNT;
        trk_crc = CRC_INIT;
    endfunction

    function automatic void track_frame_byte(input logic is_timeout, input logic [7:0] b);
        t_reading    r;
        logic [7:0]  hdr;
        if (is_timeout) begin
            record_error(KIND_TIMEOUT);
            return;
        end
        case (trk_pos)
            POS_HUNT: begin
                if (b == START_BYTE) begin
                    trk_crc = crc_modbus_byte(CRC_INIT, b);
                    trk_pos = POS_HDR1;
                end
            end
            POS_HDR1, POS_HDR2, POS_HDR3: begin
                hdr = (trk_pos == POS_HDR1) ? HDR_BYTE1 :
                      (trk_pos == POS_HDR2) ? HDR_BYTE2 : HDR_BYTE3;
                if (b != hdr) begin
                    record_error(KIND_HEADER);
                end else begin
                    trk_crc = crc_modbus_byte(trk_crc, b);
                    trk_pos = t_frame_pos'(trk_pos + 3'd1);
                end
            end
            POS_VALLO: begin
                trk_value = {8'h00, b};
                trk_crc = crc_modbus_byte(trk_crc, b);
                trk_pos = POS_VALHI;
            end
            POS_VALHI: begin
                trk_value[15:8] = b;
                trk_crc = crc_modbus_byte(trk_crc, b);
                trk_pos = POS_CRCLO;
            end
            POS_CRCLO: begin
                trk_crc_lo = b;
                trk_pos = POS_CRCHI;
            end
            default: begin
                if ({b, trk_crc_lo} != trk_crc) begin
                    record_error(KIND_CRC);
                end else begin
                    trk_last = trk_value;
                    trk_err_count = 8'h00;
                    r.value = trk_value;
                    r.valid = 1'b1;
                    r.kind = KIND_GOOD;
                    pending_readings.push_back(r);
                    trk_pos = POS_HUNT;
                    trk_crc = CRC_INIT;
                end
            end
        endcase
    endfunction

    function automatic int draw_gap(input logic quiet);
        if (quiet || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic is_timeout, input logic [7:0] b);
        int gap;
        gap = draw_gap(sender_quiet);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = is_timeout;
        i_s_axis_tdata = b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_frame_byte(is_timeout, b);
        @(negedge i_clk);
    endtask

    // A frame of eight bytes; one byte may be flipped, or the frame may be cut short
    // after cut_at bytes and closed by a timeout.
    task automatic send_frame(input logic [15:0] value, input int corrupt_at, input int cut_at);
        logic [7:0]  bytes[8];
        logic [15:0] crc;
        bytes[0] = START_BYTE;
        bytes[1] = HDR_BYTE1;
        bytes[2] = HDR_BYTE2;
        bytes[3] = HDR_BYTE3;
        bytes[4] = value[7:0];
        bytes[5] = value[15:8];
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            crc = crc_modbus_byte(crc, bytes[i]);
        end
        bytes[6] = crc[7:0];
        bytes[7] = crc[15:8];
        if (corrupt_at >= 0) begin
            bytes[corrupt_at] = bytes[corrupt_at] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < 8; i++) begin
            if (i == cut_at) begin
                send_request(1'b1, 8'($urandom));
                return;
            end
            send_request(1'b0, bytes[i]);
        end
    endtask

    task automatic wait_for_readings();
        i_s_axis_tvalid = 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
    endtask

    // Bytes that give no reading may still be in the pipeline, so let it settle.
    task automatic set_error_limit(input logic [7:0] limit);
        wait_for_readings();
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = limit;
        trk_err_limit = limit;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_hunting_and_timeout();
        send_request(1'b0, 8'h00);
        send_request(1'b1, 8'hFF);
    endtask

    task automatic test_good_frame();
        send_frame(16'hFFFF, -1, -1);
    endtask

    task automatic test_header_errors();
        // The second start byte is a header mismatch and is not taken as a new start.
        send_request(1'b0, START_BYTE);
        send_request(1'b0, START_BYTE);
        send_frame(16'h1234, 3, -1);
    endtask

    task automatic test_crc_and_timeout();
        send_frame(16'h5555, -1, 2);
        send_frame(16'h0000, 7, -1);
    endtask

    task automatic test_error_limit();
        set_error_limit(8'd0);
        send_request(1'b1, 8'h5A);
        send_frame(16'hA5C3, 6, -1);
        set_error_limit(8'd2);
        send_frame(16'h0F0F, -1, -1);
        repeat (3) send_request(1'b1, 8'($urandom));
        send_frame(16'h8001, -1, -1);
    endtask

    task automatic test_random_traffic(input int n_requests, input logic [7:0] limit,
                                       input int good_pct);
        int count;
        int pick;
        int cut;
        int junk;
        logic paused;
        count = 0;
        paused = 1'b0;
        set_error_limit(limit);
        sender_quiet = ($urandom_range(0, 3) == 0);
        reader_quiet = ($urandom_range(0, 3) == 0);
        while (count < n_requests) begin
            if ($urandom_range(0, 49) == 0) begin
                sender_quiet = ~sender_quiet;
                reader_quiet = ($urandom_range(0, 2) == 0);
            end
            if (!paused && count >= n_requests / 2) begin
                wait_for_readings();
                @(negedge i_clk);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < good_pct) begin
                send_frame(16'($urandom), -1, -1);
                count += 8;
            end else if (pick < good_pct + (100 - good_pct) * 3 / 10) begin
                send_frame(16'($urandom), $urandom_range(1, 7), -1);
                count += 8;
            end else if (pick < good_pct + (100 - good_pct) * 6 / 10) begin
                cut = $urandom_range(0, 7);
                send_frame(16'($urandom), -1, cut);
                count += cut + 1;
            end else if (pick < good_pct + (100 - good_pct) * 8 / 10) begin
                junk = $urandom_range(1, 4);
                repeat (junk) send_request(1'b0, 8'($urandom));
                count += junk;
            end else begin
                send_request(1'b1, 8'($urandom));
                count += 1;
            end
        end
    endtask

    // Readings are sampled on the rising edge.
    always @(posedge i_clk) begin : check_reading
        t_reading want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading, expected none, got value %h tuser %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                if (o_m_axis_tdata !== want.value) begin
                    $display("%0t: co2_value expected %h, got %h",
                             $time, want.value, o_m_axis_tdata);
                    fail_count++;
                end
                if (o_m_axis_tuser[0] !== want.valid) begin
                    $display("%0t: valid_res expected %b, got %b",
                             $time, want.valid, o_m_axis_tuser[0]);
                    fail_count++;
                end
                if (o_m_axis_tuser[2:1] !== want.kind) begin
                    $display("%0t: error_kind expected %0d, got %0d",
                             $time, want.kind, o_m_axis_tuser[2:1]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // The output side may stall for a random gap before each reading.
    initial begin : reading_sink
        int stall;
        wait (i_rst_n);
        forever begin
            stall = draw_gap(reader_quiet);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_hunting_and_timeout();
        test_good_frame();
        test_header_errors();
        test_crc_and_timeout();
        test_error_limit();
        test_random_traffic(200, MAX_ERRORS_RESET, 60);
        test_random_traffic(180, 8'd0, 50);
        test_random_traffic(180, 8'd255, 20);
        test_random_traffic(180, 8'd3, 15);
        test_random_traffic(180, 8'd1, 40);
        test_random_traffic(180, 8'($urandom_range(2, 254)), 30);

        wait_for_readings();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
